>>> hdl/fba_pkg.sv
`default_nettype none

package fba_pkg;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int FRAME_W  = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 8;

    // stream port widths (tdata in whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // default word count after reset
    localparam logic [CFG_W-1:0] WORDS_IN_USE_RST = 8'd128;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  granted_frame;
        logic                in_use;
    } fba_result_t;

endpackage

`default_nettype wire

>>> hdl/frame_bitmap_allocator_core.sv
// Allocate reads bitmap words in order (up to the words in use) to the first clear bit;
// free/test read the addressed word, then write or report it; range errors, frame zero frees,
// allocates with no words installed and other commands answer directly. One command at a
// time; the next is taken once the result moves to the output register, so the allocate scan
// over the single bitmap read port sets the rate. Reset (rst_n, async low) clears all
// MAX_FRAMES/WORD_BITS words (128 by default) with s_tready low; config writes always taken.
`default_nettype none

module frame_bitmap_allocator_core import fba_pkg::*; #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32      // power of two
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // command stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [11:0] frame_number, rest zero
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // [1:0] cmd

    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [11:0] granted_frame, [12] in_use, rest zero
    output logic [M_TUSER_W-1:0]      m_tuser,   // [1:0] status

    // words_in_use register
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int WORD_COUNT = MAX_FRAMES / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    logic [CFG_W-1:0]     words_in_use_reg;

    logic                 res_valid;
    logic                 res_ready;
    fba_result_t          res;

    logic                 m_tvalid_reg, m_tvalid_next;
    fba_result_t          out_res_reg, out_res_next;

    // bitmap memory port
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // config register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= WORDS_IN_USE_RST;
        end
        else if (cfg_wr_en)
        begin
            words_in_use_reg <= cfg_wr_data;
        end
    end

    fba_ctrl #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .cmd          (s_tuser[CMD_W-1:0]),
        .frame_number (s_tdata[FRAME_W-1:0]),
        .words_in_use (words_in_use_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    fba_bitmap_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: sequencer hands off a result when the slot is empty or draining,
    // so a new command can be taken while the previous result still waits
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_res_next  = out_res_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            out_res_next  = res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            out_res_reg  <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            out_res_reg  <= out_res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {{(M_TDATA_W - FRAME_W - 1){1'b0}},
                       out_res_reg.in_use, out_res_reg.granted_frame};

endmodule

`default_nettype wire

>>> hdl/fba_bitmap_ram.sv
`default_nettype none

// simple dual-port bitmap store, registered read
module fba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/fba_ctrl.sv
`default_nettype none

// command sequencer: clear pass, first-fit scan, read-modify-write
module fba_ctrl import fba_pkg::*; #(
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = 128,
    parameter int AW         = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [FRAME_W-1:0]   frame_number,
    input  wire logic [CFG_W-1:0]     words_in_use,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output fba_result_t               res,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    input  wire logic [WORD_BITS-1:0] rd_data,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [WORD_BITS-1:0]      wr_data
);

    localparam int BW      = $clog2(WORD_BITS);
    localparam int CNT_MIN = $clog2(WORD_COUNT + 1);
    localparam int CNT_W   = (CNT_MIN > CFG_W) ? CNT_MIN : CFG_W;
    localparam int CMP_W   = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
    localparam int GW      = AW + BW;
    localparam int GX      = (GW > FRAME_W) ? GW : FRAME_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RMW,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [CNT_W-1:0]    addr_reg, addr_next;
    logic [BW-1:0]       bit_reg, bit_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    fba_result_t         res_reg, res_next;

    logic [CNT_W-1:0]    wiu_ext;
    logic [CNT_W-1:0]    active_words;
    logic [CMP_W-1:0]    f_word_x;
    logic                f_valid;
    logic [CNT_W-1:0]    addr_inc;
    logic [BW-1:0]       first_free;
    logic [GX-1:0]       grant_x;

    // lowest clear bit of a word
    function automatic logic [BW-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = BW'(i);
            end
        end
        return idx;
    endfunction

    // word count from the register saturates at the bitmap size
    assign wiu_ext      = CNT_W'(words_in_use);
    assign active_words = (wiu_ext > CNT_W'(WORD_COUNT)) ? CNT_W'(WORD_COUNT) : wiu_ext;

    assign f_word_x   = CMP_W'(frame_number >> BW);
    assign f_valid    = f_word_x < CMP_W'(active_words);
    assign addr_inc   = addr_reg + 1'b1;
    assign first_free = lowest_clear(rd_data);
    assign grant_x    = GX'({addr_reg[AW-1:0], first_free});

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        addr_next  = addr_reg;
        bit_next   = bit_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = addr_reg[AW-1:0];
        wr_data    = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == AW'(WORD_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd;
                    bit_next = frame_number[BW-1:0];
                    res_next = '{status: STAT_OK, granted_frame: '0, in_use: 1'b0};
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            if (active_words == '0)
                            begin
                                res_next.status = STAT_NO_FREE;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                addr_next  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_FREE, CMD_TEST:
                        begin
                            if (!f_valid)
                            begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_RESP;
                            end
                            else if (cmd == CMD_FREE && frame_number == '0)
                            begin
                                // a free of frame zero is ignored; once granted it stays allocated
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = f_word_x[AW-1:0];
                                addr_next  = f_word_x[CNT_W-1:0];
                                state_next = ST_RMW;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (rd_data != '1)
                begin
                    wr_en                  = 1'b1;
                    wr_data                = rd_data | (WORD_BITS'(1) << first_free);
                    res_next.granted_frame = grant_x[FRAME_W-1:0];
                    state_next             = ST_RESP;
                end
                else if (addr_inc < active_words)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_inc[AW-1:0];
                    addr_next = addr_inc;
                end
                else
                begin
                    res_next.status = STAT_NO_FREE;
                    state_next      = ST_RESP;
                end
            end

            ST_RMW:
            begin
                if (cmd_reg == CMD_FREE)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data & ~(WORD_BITS'(1) << bit_reg);
                end
                else
                begin
                    res_next.in_use = rd_data[bit_reg];
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            addr_reg  <= '0;
            bit_reg   <= '0;
            cmd_reg   <= CMD_ALLOC;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            addr_reg  <= addr_next;
            bit_reg   <= bit_next;
            cmd_reg   <= cmd_next;
            res_reg   <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fba_checker.sv
`default_nettype none

module fba_checker import fba_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // failed commands carry no frame and no test bit
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_NO_FREE || m_tuser == STAT_RANGE)
        |-> m_tdata[FRAME_W:0] == '0)
        else $error("failed command returned payload");

    // a set test bit only comes with ok status and no granted frame
    a_test_bit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[FRAME_W] |-> m_tuser == STAT_OK && m_tdata[FRAME_W-1:0] == '0)
        else $error("test bit with bad status or frame");

    // status code always defined
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == STAT_OK || m_tuser == STAT_NO_FREE || m_tuser == STAT_RANGE)
        else $error("undefined status code");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:FRAME_W+1] == '0)
        else $error("nonzero padding in result");

endmodule

bind frame_bitmap_allocator_core fba_checker u_fba_checker (.*);

`default_nettype wire

>>> dv/frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 100ps

module frame_bitmap_allocator_core_tb;
    import fba_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int WORD_BITS      = 32;
    localparam int WORD_COUNT     = 128;
    localparam int FRAME_COUNT    = WORD_COUNT * WORD_BITS;
    localparam int RANDOM_CMDS    = 2000;
    localparam int TAIL_CYCLES    = 140;
    // worst case ~2400 commands, each with a long send gap, a full scan and a long stall, taken ~4x
    localparam int TIMEOUT_CYCLES = 4_000_000;

    // the block ignores this encoding; it still answers
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FRAME_W-1:0] frame;
    } alloc_cmd_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // [11:0] frame_number, rest zero
    logic [S_TUSER_W-1:0] s_tuser     = '0;   // [1:0] cmd
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // [11:0] granted_frame, [12] in_use, rest zero
    logic [M_TUSER_W-1:0] m_tuser;            // [1:0] status
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    // shadow of the allocator: bitmap plus the word count register
    logic [WORD_BITS-1:0] frame_map [WORD_COUNT];
    logic [CFG_W-1:0]     words_cfg = WORDS_IN_USE_RST;

    alloc_cmd_t  pending_cmds[$];
    fba_result_t expected_results[$];
    alloc_cmd_t  on_bus;

    int unsigned send_gap   = 0;
    int unsigned hold_ready = 0;
    bit          tx_steady  = 1'b0;
    bit          rx_steady  = 1'b0;

    int unsigned mismatches    = 0;
    int unsigned cmds_accepted = 0;
    int unsigned results_seen  = 0;
    int unsigned grants_seen   = 0;
    int unsigned no_free_seen  = 0;
    int unsigned range_seen    = 0;
    int unsigned cfg_writes    = 0;

    frame_bitmap_allocator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    initial
    begin
        foreach (frame_map[i])
            frame_map[i] = '0;
    end

    // First-fit allocator step: returns the answer to one command and
    // updates the shadow bitmap the same way the block should.
    function automatic fba_result_t allocator_step(input alloc_cmd_t c);
        fba_result_t res;
        int unsigned span;
        bit          found;
        res   = '0;
        found = 1'b0;
        // counts above the bitmap size saturate
        span  = (words_cfg > WORD_COUNT) ? WORD_COUNT : words_cfg;
        res.status = STAT_OK;
        case (c.cmd)
            CMD_ALLOC:
            begin
                res.status = STAT_NO_FREE;
                for (int w = 0; w < span && !found; w++)
                begin
                    if (frame_map[w] != '1)
                    begin
                        for (int b = 0; b < WORD_BITS && !found; b++)
                        begin
                            if (!frame_map[w][b])
                            begin
                                frame_map[w][b]   = 1'b1;
                                res.granted_frame = FRAME_W'(w * WORD_BITS + b);
                                res.status        = STAT_OK;
                                found             = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_FREE:
            begin
                if (c.frame >= span * WORD_BITS)
                    res.status = STAT_RANGE;
                else if (c.frame != 0)  // a free of frame zero is ignored
                    frame_map[c.frame[FRAME_W-1:5]][c.frame[4:0]] = 1'b0;
            end
            CMD_TEST:
            begin
                if (c.frame >= span * WORD_BITS)
                    res.status = STAT_RANGE;
                else
                    res.in_use = frame_map[c.frame[FRAME_W-1:5]][c.frame[4:0]];
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 120);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int unsigned frame);
        alloc_cmd_t c;
        c.cmd   = cmd;
        c.frame = FRAME_W'(frame);
        pending_cmds.push_back(c);
    endtask

    // wait until every queued command has been sent and answered
    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // only called with the block idle, so the shadow can change at once
    task automatic write_words(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        words_cfg    = value;
        cfg_writes++;
        @(negedge clk);
    endtask

    // Command driver: predicts at the accepting edge, then either holds,
    // idles for a while, or puts the next queued command on the bus.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(allocator_step(on_bus));
                cmds_accepted++;
                if (on_bus.cmd == CMD_ALLOC)
                    grants_seen++;
                if ($urandom_range(0, 63) == 0)
                    tx_steady = !tx_steady;
                send_gap = (tx_steady || $urandom_range(0, 1)) ? 0 : idle_len();
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    on_bus    = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.cmd;
                    s_tdata  <= {{(S_TDATA_W - FRAME_W){1'b0}}, on_bus.frame};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer against the oldest prediction
    // and throttles m_tready with random stalls.
    always @(posedge clk)
    begin : result_check
        fba_result_t got;
        fba_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status        = m_tuser[STATUS_W-1:0];
                got.granted_frame = m_tdata[FRAME_W-1:0];
                got.in_use        = m_tdata[FRAME_W];
                if (expected_results.size() == 0)
                begin
                    flag_mismatch($sformatf("result with nothing outstanding: status=%0d frame=%0d",
                                            got.status, got.granted_frame));
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (got.status !== want.status)
                        flag_mismatch($sformatf("result %0d: status %0d, want %0d",
                                                results_seen, got.status, want.status));
                    if (got.granted_frame !== want.granted_frame)
                        flag_mismatch($sformatf("result %0d: granted_frame %0d, want %0d",
                                                results_seen, got.granted_frame,
                                                want.granted_frame));
                    if (got.in_use !== want.in_use)
                        flag_mismatch($sformatf("result %0d: in_use %0b, want %0b",
                                                results_seen, got.in_use, want.in_use));
                    case (want.status)
                        STAT_NO_FREE: no_free_seen++;
                        STAT_RANGE:   range_seen++;
                        default:      ;
                    endcase
                end
                if ($urandom_range(0, 63) == 0)
                    rx_steady = !rx_steady;
            end
            if (hold_ready > 0)
            begin
                hold_ready--;
                m_tready <= 1'b0;
            end
            else if (!rx_steady && $urandom_range(0, 7) == 0)
            begin
                hold_ready = idle_len();
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned random_cmds;
        int unsigned span_frames;
        int unsigned n_cmds;
        int unsigned mode;
        int unsigned r;
        int unsigned f;
        logic [CFG_W-1:0] wv;
        logic [CMD_W-1:0] cmd;

        random_cmds = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset word count, first-fit order, frame zero protection,
        // double free, top frame, unused command
        queue_cmd(CMD_TEST, 0);
        queue_cmd(CMD_ALLOC, 0);
        queue_cmd(CMD_ALLOC, 0);
        queue_cmd(CMD_TEST, 1);
        queue_cmd(CMD_TEST, FRAME_COUNT - 1);
        queue_cmd(CMD_FREE, 0);
        queue_cmd(CMD_TEST, 0);
        queue_cmd(CMD_FREE, 1);
        queue_cmd(CMD_FREE, 1);
        queue_cmd(CMD_TEST, 1);
        queue_cmd(CMD_ALLOC, 0);
        queue_cmd(CMD_UNUSED, FRAME_COUNT - 1);
        queue_cmd(CMD_FREE, FRAME_COUNT - 1);
        queue_cmd(CMD_ALLOC, FRAME_COUNT - 1);
        drain();

        // nothing installed
        write_words(8'd0);
        queue_cmd(CMD_ALLOC, 0);
        queue_cmd(CMD_FREE, 5);
        queue_cmd(CMD_TEST, 0);
        drain();

        // single word: last frame in range and first one past it
        write_words(8'd1);
        queue_cmd(CMD_TEST, WORD_BITS - 1);
        queue_cmd(CMD_TEST, WORD_BITS);
        queue_cmd(CMD_FREE, WORD_BITS);
        drain();

        // count above the bitmap size saturates
        write_words(8'd255);
        queue_cmd(CMD_TEST, FRAME_COUNT - 1);
        queue_cmd(CMD_TEST, 3000);
        drain();

        // Random phases. The bitmap carries over from phase to phase, so
        // fill-heavy phases at small counts run into exhaustion and later
        // phases at larger counts scan past the filled words.
        while (random_cmds < RANDOM_CMDS)
        begin
            r = $urandom_range(0, 11);
            case (r)
                0:       wv = 8'd0;
                1:       wv = 8'd1;
                2:       wv = 8'(WORD_COUNT);
                3:       wv = 8'($urandom_range(WORD_COUNT + 1, 255));
                4, 5, 6: wv = 8'($urandom_range(2, 8));
                7, 8:    wv = 8'($urandom_range(9, 40));
                9:       wv = 8'($urandom_range(41, WORD_COUNT - 1));
                default: wv = 8'($urandom_range(1, 4));
            endcase
            write_words(wv);
            span_frames = ((wv > WORD_COUNT) ? WORD_COUNT : wv) * WORD_BITS;
            n_cmds      = $urandom_range(80, 300);
            mode        = $urandom_range(0, 2);  // 0,1 fill-heavy, 2 churn

            repeat (n_cmds)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    cmd = CMD_UNUSED;
                else if (mode != 2)
                    cmd = (r < 72) ? CMD_ALLOC : (r < 84) ? CMD_FREE : CMD_TEST;
                else
                    cmd = (r < 40) ? CMD_ALLOC : (r < 70) ? CMD_FREE : CMD_TEST;

                case ($urandom_range(0, 9))
                    0:       f = $urandom_range(0, FRAME_COUNT - 1);
                    1:       f = (span_frames < FRAME_COUNT) ? span_frames : FRAME_COUNT - 1;
                    2:       f = (span_frames > 0) ? span_frames - 1 : 0;
                    3, 4:    f = $urandom_range(0, 40);
                    default: f = (span_frames > 0) ? $urandom_range(0, span_frames - 1)
                                                   : $urandom_range(0, FRAME_COUNT - 1);
                endcase
                // frame field is don't-care for these; keep its bits moving
                if (cmd == CMD_ALLOC || cmd == CMD_UNUSED)
                    f = $urandom_range(0, FRAME_COUNT - 1);
                queue_cmd(cmd, f);
                random_cmds++;
            end
            drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d commands over %0d word-count writes",
                 results_seen, cmds_accepted, cfg_writes);
        $display("Allocate requests %0d, no-free answers %0d, out-of-range answers %0d",
                 grants_seen, no_free_seen, range_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout: %0d commands accepted, %0d results outstanding",
                 cmds_accepted, expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
